// ----- design/pfct_pkg.sv -----
`default_nettype none
package pfct_pkg;

	localparam int DEPTH_DEFAULT = 64;
	localparam int KEY_W         = 32;
	localparam int CNT_W         = 32;
	localparam logic [KEY_W-1:0] IDENT_ABSENT = 32'h7FFF_FFFF;

	typedef enum logic [2:0] {
		ST_COUNTED  = 3'd0,
		ST_INSERTED = 3'd1,
		ST_FULL     = 3'd2,
		ST_REJECTED = 3'd3,
		ST_DUMP     = 3'd4,
		ST_EMPTY    = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_ADD,
		CELL_SORT,
		CELL_SHIFT
	} cell_op_t;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_EXEC,
		FSM_SORT,
		FSM_DUMP
	} fsm_t;

	typedef struct packed {
		logic [KEY_W-1:0] cls;
		logic [KEY_W-1:0] idn;
		logic [CNT_W-1:0] count;
	} entry_t;

	typedef struct packed {
		cell_op_t         op;
		logic             phase;
		logic             insert;
		logic [KEY_W-1:0] key_cls;
		logic [KEY_W-1:0] key_idn;
	} cell_ctrl_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
		sat_inc = (c == '1) ? c : c + CNT_W'(1);
	endfunction

endpackage
`default_nettype wire

// ----- design/pair_frequency_count_table_core.sv -----
`default_nettype none
// Channel  Handshake            Payload
// in       in_valid/in_ready    opcode class_value class_valid ident_value ident_present
// out      out_valid/out_ready  status out_class out_ident out_count last
//
// Add: accepted while idle, then looked up and updated across the cells in the execute
// state once the output register can load; the next item is taken only after that step.
// Dump: odd-even transposition sort by count between neighbor cells, then one entry
// per cycle shifted out of cell 0 while the output register can load.
// Reset clears the fill count and control; entry contents are undefined until written.
// A stalled out_ready holds the execute and dump steps (the sort runs on); a new item may be taken while the
// final result still waits, and it executes once the output register can load.
module pair_frequency_count_table_core import pfct_pkg::*; #(
	parameter int TABLE_DEPTH = DEPTH_DEFAULT
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic               opcode,
	input  wire logic signed [31:0] class_value,
	input  wire logic               class_valid,
	input  wire logic signed [31:0] ident_value,
	input  wire logic               ident_present,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic             [2:0]  status,
	output logic signed      [31:0] out_class,
	output logic signed      [31:0] out_ident,
	output logic             [31:0] out_count,
	output logic                    last
);

	localparam int UW = $clog2(TABLE_DEPTH + 1);

	fsm_t             state_q, state_d;
	logic [UW-1:0]    used_q, used_d;
	logic [UW-1:0]    cnt_q, cnt_d;
	logic             op_q, cvalid_q;
	logic [KEY_W-1:0] cls_q, idn_q;

	logic             out_valid_q;
	status_t          status_q, status_d;
	logic [KEY_W-1:0] oclass_q, oclass_d, oident_q, oident_d;
	logic [CNT_W-1:0] ocount_q, ocount_d;
	logic             last_q, last_d;
	logic             out_load, load_ok;

	cell_ctrl_t               ctrl;
	entry_t                   ent [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0]   match;
	logic                     hit, full;
	logic [CNT_W-1:0]         hit_count;

	genvar gi;
	generate
		for (gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
			pfct_cell #(.TABLE_DEPTH(TABLE_DEPTH), .IDX(gi)) u_cell (
				.clk       (clk),
				.ctrl      (ctrl),
				.used      (used_q),
				.left_ent  (ent[(gi + TABLE_DEPTH - 1) % TABLE_DEPTH]),
				.right_ent (ent[(gi + 1) % TABLE_DEPTH]),
				.wrap_ent  (ent[0]),
				.ent       (ent[gi]),
				.match     (match[gi])
			);
		end
	endgenerate

	always_comb begin
		hit_count = '0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			hit_count = hit_count | (match[i] ? ent[i].count : '0);
		end
	end

	assign hit      = |match;
	assign full     = used_q == UW'(TABLE_DEPTH);
	assign load_ok  = !out_valid_q || out_ready;
	assign in_ready = state_q == FSM_IDLE;

	always_comb begin
		state_d = state_q;
		case (state_q)
			FSM_IDLE: begin
				if (in_valid) state_d = FSM_EXEC;
			end
			FSM_EXEC: begin
				if (load_ok) begin
					state_d = (op_q && used_q != '0) ? FSM_SORT : FSM_IDLE;
				end
			end
			FSM_SORT: begin
				if (cnt_q == UW'(TABLE_DEPTH - 1)) state_d = FSM_DUMP;
			end
			FSM_DUMP: begin
				if (load_ok && cnt_q == used_q - UW'(1)) state_d = FSM_IDLE;
			end
			default: state_d = FSM_IDLE;
		endcase
	end

	always_comb begin
		ctrl.op      = CELL_HOLD;
		ctrl.phase   = cnt_q[0];
		ctrl.insert  = 1'b0;
		ctrl.key_cls = cls_q;
		ctrl.key_idn = idn_q;
		used_d       = used_q;
		cnt_d        = cnt_q;
		out_load     = 1'b0;
		status_d     = status_q;
		oclass_d     = '0;
		oident_d     = '0;
		ocount_d     = '0;
		last_d       = 1'b1;
		case (state_q)
			FSM_EXEC: begin
				cnt_d = '0;
				if (load_ok) begin
					if (op_q) begin
						if (used_q == '0) begin
							out_load = 1'b1;
							status_d = ST_EMPTY;
						end
					end else if (!cvalid_q) begin
						out_load = 1'b1;
						status_d = ST_REJECTED;
					end else begin
						out_load    = 1'b1;
						ctrl.op     = CELL_ADD;
						ctrl.insert = !hit && !full;
						oclass_d    = cls_q;
						oident_d    = idn_q;
						if (hit) begin
							status_d = ST_COUNTED;
							ocount_d = sat_inc(hit_count);
						end else if (full) begin
							status_d = ST_FULL;
						end else begin
							status_d = ST_INSERTED;
							ocount_d = CNT_W'(1);
							used_d   = used_q + UW'(1);
						end
					end
				end
			end
			FSM_SORT: begin
				ctrl.op = CELL_SORT;
				cnt_d   = (cnt_q == UW'(TABLE_DEPTH - 1)) ? '0 : cnt_q + UW'(1);
			end
			FSM_DUMP: begin
				if (load_ok) begin
					ctrl.op  = CELL_SHIFT;
					out_load = 1'b1;
					status_d = ST_DUMP;
					oclass_d = ent[0].cls;
					oident_d = ent[0].idn;
					ocount_d = ent[0].count;
					last_d   = cnt_q == used_q - UW'(1);
					cnt_d    = cnt_q + UW'(1);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= FSM_IDLE;
			used_q      <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			used_q  <= used_d;
			cnt_q   <= cnt_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q     <= opcode;
			cvalid_q <= class_valid;
			cls_q    <= class_value;
			idn_q    <= ident_present ? ident_value : IDENT_ABSENT;
		end
		if (out_load) begin
			status_q <= status_d;
			oclass_q <= oclass_d;
			oident_q <= oident_d;
			ocount_q <= ocount_d;
			last_q   <= last_d;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign out_class = oclass_q;
	assign out_ident = oident_q;
	assign out_count = ocount_q;
	assign last      = last_q;

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= UW'(TABLE_DEPTH))
		else $error("fill count beyond table depth");

	a_unique_key: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == FSM_EXEC) |-> $onehot0(match))
		else $error("key pair held by more than one cell");

	a_insert_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.op == CELL_ADD && ctrl.insert) |=> (used_q == $past(used_q) + UW'(1)))
		else $error("insert did not advance fill count");

	a_dump_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == FSM_DUMP && out_load && last_d) |=> (state_q == FSM_IDLE && last_q))
		else $error("dump did not end on its last entry");

endmodule
`default_nettype wire

// ----- design/pfct_cell.sv -----
`default_nettype none
module pfct_cell import pfct_pkg::*; #(
	parameter int TABLE_DEPTH = DEPTH_DEFAULT,
	parameter int IDX         = 0
) (
	input  wire logic                             clk,
	input  wire cell_ctrl_t                       ctrl,
	input  wire logic [$clog2(TABLE_DEPTH+1)-1:0] used,
	input  wire entry_t                           left_ent,
	input  wire entry_t                           right_ent,
	input  wire entry_t                           wrap_ent,
	output entry_t                                ent,
	output logic                                  match
);

	localparam int UW = $clog2(TABLE_DEPTH + 1);

	entry_t ent_q;
	entry_t ent_d;
	logic   occ, occ_r, tail, lo_role, hi_role, swap_lo, swap_hi;

	assign occ     = UW'(IDX) < used;
	assign occ_r   = UW'(IDX + 1) < used;
	assign tail    = UW'(IDX + 1) == used;
	assign lo_role = 1'(IDX % 2) == ctrl.phase;
	assign hi_role = (IDX > 0) && !lo_role && occ;
	assign swap_lo = lo_role && occ_r && (ent_q.count < right_ent.count);
	assign swap_hi = hi_role && (left_ent.count < ent_q.count);
	assign match   = occ && (ent_q.cls == ctrl.key_cls) && (ent_q.idn == ctrl.key_idn);

	always_comb begin
		ent_d = ent_q;
		case (ctrl.op)
			CELL_ADD: begin
				if (match) begin
					ent_d.count = sat_inc(ent_q.count);
				end else if (ctrl.insert && (UW'(IDX) == used)) begin
					ent_d.cls   = ctrl.key_cls;
					ent_d.idn   = ctrl.key_idn;
					ent_d.count = CNT_W'(1);
				end
			end
			CELL_SORT: begin
				if (swap_lo) begin
					ent_d = right_ent;
				end else if (swap_hi) begin
					ent_d = left_ent;
				end
			end
			CELL_SHIFT: begin
				if (occ) begin
					ent_d = tail ? wrap_ent : right_ent;
				end
			end
			default: ent_d = ent_q;
		endcase
	end

	always_ff @(posedge clk) begin
		ent_q <= ent_d;
	end

	assign ent = ent_q;

endmodule
`default_nettype wire
